/* rtl/cmts_pkg.sv */
// cmts_pkg: shared types, codes and constants of the context model text scorer
// used by every module of the block; depends on nothing
`default_nettype none
package cmts_pkg;

   localparam int MAX_ORDER_DEF   = 2;
   localparam int SYMBOL_BITS_DEF = 6;
   localparam int COST_BITS_DEF   = 40;

   localparam int QUEUE_DEPTH  = 2;
   localparam int LOG_IN_BITS  = 42;
   localparam int FRAC_BITS    = 16;
   localparam int EXP_BITS     = 6;
   localparam int LOG_OUT_BITS = EXP_BITS + FRAC_BITS;
   localparam int MANT_BITS    = 32;

   localparam logic [1:0] CMD_SCORE = 2'd0;
   localparam logic [1:0] CMD_MAP   = 2'd1;
   localparam logic [1:0] CMD_COUNT = 2'd2;

   localparam logic [1:0] OP_SCORE   = 2'd0;
   localparam logic [1:0] OP_MAP_SET = 2'd1;
   localparam logic [1:0] OP_MAP_CLR = 2'd2;
   localparam logic [1:0] OP_COUNT   = 2'd3;

   localparam logic [1:0] CSR_ORDER = 2'd0;
   localparam logic [1:0] CSR_ASIZE = 2'd1;
   localparam logic [1:0] CSR_ALPHA = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic        has_byte;
      logic [7:0]  byte_value;
      logic [6:0]  symbol;
      logic        which;
      logic [11:0] ctx;
      logic [31:0] count;
      logic        last;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/context_model_text_scorer.sv */
// context_model_text_scorer: top level of the order-k two-model text scorer
// depends on cmts_pkg, cmts_front, cmts_queue, cmts_back
//
// req_ beats carry score bytes, alphabet map loads and count table loads; a
// beat is taken when req_valid is high and req_stall low. csr_ writes set
// context order (index 0), alphabet size (1) and alpha (2); csr_ready is
// always high. A result beat on rsp_ appears only for a score beat with last
// set, held in an output register until rsp_stall is low.
// Beats pass through a two-entry queue to the executing back end, one at a
// time. Loads pass through the idle and execute states only, a beat without a
// byte also through the finish state, a byte that is dropped or only builds
// the context through the map state too, and a scored byte also through the
// read state and four log2 runs (start, leading one search, 16 squaring steps,
// done) on the single shared log2 unit. At a sample end the back end waits only
// while the previous result is still held by the receiver.
// After reset the row presence tables, 2**(MAX_ORDER*SYMBOL_BITS) rows (4096 by
// default), are cleared one row per cycle with req_stall high.
// A stalled receiver holds the result; the back end then waits at the next
// sample end and the queue fills, raising req_stall.
`default_nettype none
module context_model_text_scorer #(
   parameter int MAX_ORDER   = cmts_pkg::MAX_ORDER_DEF,
   parameter int SYMBOL_BITS = cmts_pkg::SYMBOL_BITS_DEF,
   parameter int COST_BITS   = cmts_pkg::COST_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic        req_has_byte,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_map_enable,
   input  wire logic [6:0]  req_symbol_index,
   input  wire logic        req_which_model,
   input  wire logic [11:0] req_context_code,
   input  wire logic [31:0] req_count_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [39:0]      rsp_human_cost,
   output logic [39:0]      rsp_ai_cost,
   output logic             rsp_verdict,
   output logic             rsp_skipped,
   output logic [31:0]      rsp_human_tally,
   output logic [31:0]      rsp_ai_tally,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import cmts_pkg::*;

   entry_type push_data, head;
   logic      push, pop, full, empty, clearing;

   cmts_front #(.SYMBOL_BITS(SYMBOL_BITS)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_has_byte     (req_has_byte),
      .req_byte_value   (req_byte_value),
      .req_map_enable   (req_map_enable),
      .req_symbol_index (req_symbol_index),
      .req_which_model  (req_which_model),
      .req_context_code (req_context_code),
      .req_count_value  (req_count_value),
      .req_last         (req_last),
      .queue_full       (full),
      .clearing         (clearing),
      .push             (push),
      .push_data        (push_data)
   );

   cmts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   cmts_back #(
      .MAX_ORDER   (MAX_ORDER),
      .SYMBOL_BITS (SYMBOL_BITS),
      .COST_BITS   (COST_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .queue_empty     (empty),
      .queue_head      (head),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_human_cost  (rsp_human_cost),
      .rsp_ai_cost     (rsp_ai_cost),
      .rsp_verdict     (rsp_verdict),
      .rsp_skipped     (rsp_skipped),
      .rsp_human_tally (rsp_human_tally),
      .rsp_ai_tally    (rsp_ai_tally)
   );
endmodule
`default_nettype wire

/* rtl/cmts_log2.sv */
// cmts_log2: iterative fixed point log2, normalize then 16 squaring steps
// depends on cmts_pkg
`default_nettype none
module cmts_log2 (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [cmts_pkg::LOG_IN_BITS-1:0]  x,
   output logic                                  done,
   output logic [cmts_pkg::LOG_OUT_BITS-1:0]      result
);
   import cmts_pkg::*;

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQ   = 2'd2;
   localparam int SW = $clog2(FRAC_BITS + 1);

   logic [1:0]             st_ff, st_in;
   logic [LOG_IN_BITS-1:0] x_ff, x_in;
   logic [EXP_BITS-1:0]    e_ff, e_in;
   logic [MANT_BITS-1:0]   m_ff, m_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [SW-1:0]          step_ff, step_in;
   logic                   done_ff, done_in;
   logic [2*MANT_BITS-1:0] prod;
   logic [MANT_BITS:0]     sq;

   assign prod = m_ff * m_ff;
   assign sq   = prod[2*MANT_BITS-1:MANT_BITS-1];

   always_comb begin
      st_in   = st_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      step_in = step_ff;
      done_in = 1'b0;
      case (st_ff)
         L_IDLE: begin
            if (start) begin
               x_in    = x;
               e_in    = EXP_BITS'(LOG_IN_BITS - 1);
               frac_in = '0;
               if (x == '0) begin
                  e_in    = '0;
                  done_in = 1'b1;
               end else begin
                  st_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            if (x_ff[LOG_IN_BITS-1]) begin
               m_in    = x_ff[LOG_IN_BITS-1 -: MANT_BITS];
               step_in = '0;
               st_in   = L_SQ;
            end else if (x_ff[LOG_IN_BITS-1 -: 8] == 8'd0) begin
               x_in = x_ff << 8;
               e_in = e_ff - EXP_BITS'(8);
            end else begin
               x_in = x_ff << 1;
               e_in = e_ff - EXP_BITS'(1);
            end
         end
         L_SQ: begin
            if (sq[MANT_BITS]) begin
               m_in    = sq[MANT_BITS:1];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = sq[MANT_BITS-1:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(FRAC_BITS - 1)) begin
               done_in = 1'b1;
               st_in   = L_IDLE;
            end
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};
endmodule
`default_nettype wire

/* rtl/cmts_queue.sv */
// cmts_queue: short in-order queue of decoded beats between front and back
// depends on cmts_pkg
`default_nettype none
module cmts_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cmts_pkg::entry_type push_data,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output cmts_pkg::entry_type      head
);
   import cmts_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* rtl/cmts_front.sv */
// cmts_front: input beat acceptance and command decode into queue entries
// depends on cmts_pkg
`default_nettype none
module cmts_front #(
   parameter int SYMBOL_BITS = cmts_pkg::SYMBOL_BITS_DEF
) (
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_cmd,
   input  wire logic          req_has_byte,
   input  wire logic [7:0]    req_byte_value,
   input  wire logic          req_map_enable,
   input  wire logic [6:0]    req_symbol_index,
   input  wire logic          req_which_model,
   input  wire logic [11:0]   req_context_code,
   input  wire logic [31:0]   req_count_value,
   input  wire logic          req_last,
   input  wire logic          queue_full,
   input  wire logic          clearing,
   output logic               push,
   output cmts_pkg::entry_type push_data
);
   import cmts_pkg::*;

   localparam int NSYM = 1 << SYMBOL_BITS;

   logic keep;
   logic [8:0] sidx;

   assign sidx      = 9'(req_symbol_index);
   assign req_stall = queue_full | clearing;
   assign push      = req_valid & ~req_stall & keep;

   always_comb begin
      keep                 = 1'b0;
      push_data.op         = OP_SCORE;
      push_data.has_byte   = req_has_byte;
      push_data.byte_value = req_byte_value;
      push_data.symbol     = req_symbol_index;
      push_data.which      = req_which_model;
      push_data.ctx        = req_context_code;
      push_data.count      = req_count_value;
      push_data.last       = req_last;
      case (req_cmd)
         CMD_SCORE: keep = 1'b1;
         CMD_MAP: begin
            keep = 1'b1;
            push_data.op = (req_map_enable && sidx < 9'(NSYM)) ? OP_MAP_SET : OP_MAP_CLR;
         end
         CMD_COUNT: begin
            keep = (sidx <= 9'(NSYM));
            push_data.op = OP_COUNT;
         end
         default: keep = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/cmts_back.sv */
// cmts_back: executes queued beats: alphabet map, count tables, cost sums, results
// depends on cmts_pkg and cmts_log2
`default_nettype none
module cmts_back #(
   parameter int MAX_ORDER   = cmts_pkg::MAX_ORDER_DEF,
   parameter int SYMBOL_BITS = cmts_pkg::SYMBOL_BITS_DEF,
   parameter int COST_BITS   = cmts_pkg::COST_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_data,
   input  wire logic                queue_empty,
   input  wire cmts_pkg::entry_type queue_head,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [39:0]              rsp_human_cost,
   output logic [39:0]              rsp_ai_cost,
   output logic                     rsp_verdict,
   output logic                     rsp_skipped,
   output logic [31:0]              rsp_human_tally,
   output logic [31:0]              rsp_ai_tally
);
   import cmts_pkg::*;

   localparam int NSYM      = 1 << SYMBOL_BITS;
   localparam int COLS      = NSYM + 1;
   localparam int ROW_BITS  = MAX_ORDER * SYMBOL_BITS;
   localparam int ROWS      = 1 << ROW_BITS;
   localparam int ADDR_BITS = ROW_BITS + SYMBOL_BITS + 1;
   localparam int NW        = SYMBOL_BITS + 1;
   localparam int KW        = $clog2(MAX_ORDER + 1);
   localparam int ANW       = 16 + NW;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_MAP    = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_LOG    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]  st_ff, st_in;
   entry_type   cur_ff;
   logic [1:0]  ord_ff;
   logic [6:0]  asz_ff;
   logic [15:0] alpha_ff;

   logic [KW-1:0]  k_eff;
   logic [NW-1:0]  n_eff;
   logic [15:0]    a_eff;
   logic [ROW_BITS-1:0] mask;

   // alphabet map
   logic                   map_vld_ff [256];
   logic [SYMBOL_BITS-1:0] map_mem [0:255];
   logic [SYMBOL_BITS-1:0] sym_rd_ff;
   logic                   vld_rd_ff;
   logic                   kept;

   // count tables and row presence
   logic [31:0] hum_mem [0:ROWS*COLS-1];
   logic [31:0] ai_mem  [0:ROWS*COLS-1];
   logic        hpres_mem [0:ROWS-1];
   logic        apres_mem [0:ROWS-1];
   logic [31:0] hum_tot_ff, hum_cnt_ff, ai_tot_ff, ai_cnt_ff;
   logic        hpres_ff, apres_ff;
   logic [ROW_BITS-1:0] clr_ff, clr_in;
   logic [ROW_BITS-1:0] wrow, rrow;
   logic [ADDR_BITS-1:0] waddr, rbase, addr_tot, addr_cnt;
   logic        count_we, rd_en;

   // sample state
   logic [ROW_BITS-1:0]  ctx_ff, ctx_in, ctx_next;
   logic [KW-1:0]        seen_ff, seen_in;
   logic [COST_BITS-1:0] hacc_ff, hacc_in, aacc_ff, aacc_in;
   logic [31:0]          htal_ff, htal_in, atal_ff, atal_in;

   // log2 sequencing
   logic [LOG_IN_BITS-1:0]  dh_ff, qh_ff, da_ff, qa_ff;
   logic [ANW-1:0]          an;
   logic [1:0]              ph_ff, ph_in;
   logic                    lstart_ff, lstart_in;
   logic [LOG_IN_BITS-1:0]  lx;
   logic                    ldone;
   logic [LOG_OUT_BITS-1:0] lres, ld_ff, ld_in, term;
   logic [COST_BITS:0]      hsum, asum;

   // result register
   logic        rv_ff, rv_in, load_rsp, skip, ai_win;
   logic [39:0] rh_ff, ra_ff;
   logic        rverd_ff, rskip_ff;
   logic [31:0] rht_ff, rat_ff;

   assign csr_ready = 1'b1;
   assign clearing  = (st_ff == ST_CLEAR);

   always_comb begin
      if (ord_ff == 2'd0) begin
         k_eff = KW'(1);
      end else if (int'(ord_ff) > MAX_ORDER) begin
         k_eff = KW'(MAX_ORDER);
      end else begin
         k_eff = KW'(ord_ff);
      end
      if (asz_ff == 7'd0) begin
         n_eff = NW'(1);
      end else if (int'(asz_ff) > NSYM) begin
         n_eff = NW'(NSYM);
      end else begin
         n_eff = NW'(asz_ff);
      end
      a_eff = (alpha_ff == 16'd0) ? 16'd1 : alpha_ff;
      for (int j = 0; j < MAX_ORDER; j++) begin
         mask[j*SYMBOL_BITS +: SYMBOL_BITS] = (j < int'(k_eff)) ? '1 : '0;
      end
   end

   assign kept     = vld_rd_ff && (NW'(sym_rd_ff) < n_eff);
   assign ctx_next = ((ctx_ff << SYMBOL_BITS) | ROW_BITS'(sym_rd_ff)) & mask;

   assign wrow     = ROW_BITS'(cur_ff.ctx);
   assign waddr    = ADDR_BITS'({wrow, {SYMBOL_BITS{1'b0}}}) + ADDR_BITS'(wrow)
                     + ADDR_BITS'(cur_ff.symbol);
   assign rrow     = ctx_ff & mask;
   assign rbase    = ADDR_BITS'({rrow, {SYMBOL_BITS{1'b0}}}) + ADDR_BITS'(rrow);
   assign addr_tot = rbase + ADDR_BITS'(n_eff);
   assign addr_cnt = rbase + ADDR_BITS'(sym_rd_ff);
   assign count_we = (st_ff == ST_EXEC) && (cur_ff.op == OP_COUNT);
   assign rd_en    = (st_ff == ST_MAP) && kept && (seen_ff >= k_eff);

   assign an = ANW'(a_eff) * ANW'(n_eff);

   always_comb begin
      case (ph_ff)
         2'd0:    lx = dh_ff;
         2'd1:    lx = qh_ff;
         2'd2:    lx = da_ff;
         default: lx = qa_ff;
      endcase
   end

   cmts_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (lstart_ff),
      .x      (lx),
      .done   (ldone),
      .result (lres)
   );

   assign term = (ld_ff >= lres) ? ld_ff - lres : '0;
   assign hsum = {1'b0, hacc_ff} + (COST_BITS+1)'(term);
   assign asum = {1'b0, aacc_ff} + (COST_BITS+1)'(term);

   assign skip     = seen_ff < k_eff;
   assign ai_win   = !skip && (hacc_ff > aacc_ff);
   assign load_rsp = (st_ff == ST_FINISH) && cur_ff.last && (!rv_ff || !rsp_stall);
   assign pop      = (st_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      st_in     = st_ff;
      clr_in    = clr_ff;
      ctx_in    = ctx_ff;
      seen_in   = seen_ff;
      hacc_in   = hacc_ff;
      aacc_in   = aacc_ff;
      htal_in   = htal_ff;
      atal_in   = atal_ff;
      ph_in     = ph_ff;
      lstart_in = 1'b0;
      ld_in     = ld_ff;
      rv_in     = rv_ff & rsp_stall;
      case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ROW_BITS'(1);
            if (clr_ff == '1) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.op == OP_SCORE) begin
               st_in = cur_ff.has_byte ? ST_MAP : ST_FINISH;
            end else begin
               st_in = ST_IDLE;
            end
         end
         ST_MAP: begin
            if (!kept) begin
               st_in = ST_FINISH;
            end else if (seen_ff < k_eff) begin
               seen_in = seen_ff + KW'(1);
               ctx_in  = ctx_next;
               st_in   = ST_FINISH;
            end else begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            ph_in     = 2'd0;
            lstart_in = 1'b1;
            st_in     = ST_LOG;
         end
         ST_LOG: begin
            if (ldone) begin
               case (ph_ff)
                  2'd0, 2'd2: ld_in = lres;
                  2'd1:    hacc_in = hsum[COST_BITS] ? '1 : hsum[COST_BITS-1:0];
                  default: aacc_in = asum[COST_BITS] ? '1 : asum[COST_BITS-1:0];
               endcase
               if (ph_ff == 2'd3) begin
                  ctx_in = ctx_next;
                  st_in  = ST_FINISH;
               end else begin
                  ph_in     = ph_ff + 2'd1;
                  lstart_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!cur_ff.last) begin
               st_in = ST_IDLE;
            end else if (load_rsp) begin
               if (!skip) begin
                  if (ai_win) begin
                     if (atal_ff != '1) atal_in = atal_ff + 32'd1;
                  end else begin
                     if (htal_ff != '1) htal_in = htal_ff + 32'd1;
                  end
               end
               rv_in   = 1'b1;
               ctx_in  = '0;
               seen_in = '0;
               hacc_in = '0;
               aacc_in = '0;
               st_in   = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_CLEAR;
         clr_ff    <= '0;
         ord_ff    <= 2'd2;
         asz_ff    <= 7'd64;
         alpha_ff  <= 16'd256;
         ctx_ff    <= '0;
         seen_ff   <= '0;
         hacc_ff   <= '0;
         aacc_ff   <= '0;
         htal_ff   <= '0;
         atal_ff   <= '0;
         lstart_ff <= 1'b0;
         ph_ff     <= '0;
         rv_ff     <= 1'b0;
         for (int i = 0; i < 256; i++) begin
            map_vld_ff[i] <= 1'b0;
         end
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         ctx_ff    <= ctx_in;
         seen_ff   <= seen_in;
         hacc_ff   <= hacc_in;
         aacc_ff   <= aacc_in;
         htal_ff   <= htal_in;
         atal_ff   <= atal_in;
         lstart_ff <= lstart_in;
         ph_ff     <= ph_in;
         rv_ff     <= rv_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ORDER: ord_ff   <= csr_data[1:0];
               CSR_ASIZE: asz_ff   <= csr_data[6:0];
               CSR_ALPHA: alpha_ff <= csr_data;
               default:   ord_ff   <= ord_ff;
            endcase
         end
         if (st_ff == ST_EXEC && cur_ff.op == OP_MAP_SET) begin
            map_vld_ff[cur_ff.byte_value] <= 1'b1;
         end else if (st_ff == ST_EXEC && cur_ff.op == OP_MAP_CLR) begin
            map_vld_ff[cur_ff.byte_value] <= 1'b0;
         end
      end
      if (pop) begin
         cur_ff <= queue_head;
      end
      ld_ff <= ld_in;
      if (st_ff == ST_EXEC) begin
         vld_rd_ff <= map_vld_ff[cur_ff.byte_value];
      end
      if (st_ff == ST_READ) begin
         dh_ff <= hpres_ff ? LOG_IN_BITS'({hum_tot_ff, 8'h00}) + LOG_IN_BITS'(an)
                           : LOG_IN_BITS'(n_eff);
         qh_ff <= hpres_ff ? LOG_IN_BITS'({hum_cnt_ff, 8'h00}) + LOG_IN_BITS'(a_eff)
                           : LOG_IN_BITS'(1);
         da_ff <= apres_ff ? LOG_IN_BITS'({ai_tot_ff, 8'h00}) + LOG_IN_BITS'(an)
                           : LOG_IN_BITS'(n_eff);
         qa_ff <= apres_ff ? LOG_IN_BITS'({ai_cnt_ff, 8'h00}) + LOG_IN_BITS'(a_eff)
                           : LOG_IN_BITS'(1);
      end
      if (load_rsp) begin
         rh_ff    <= skip ? 40'd0 : 40'(hacc_ff);
         ra_ff    <= skip ? 40'd0 : 40'(aacc_ff);
         rverd_ff <= ai_win;
         rskip_ff <= skip;
         rht_ff   <= htal_in;
         rat_ff   <= atal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_EXEC && cur_ff.op == OP_MAP_SET) begin
         map_mem[cur_ff.byte_value] <= cur_ff.symbol[SYMBOL_BITS-1:0];
      end
      if (st_ff == ST_EXEC) begin
         sym_rd_ff <= map_mem[cur_ff.byte_value];
      end
   end

   always_ff @(posedge clock) begin
      if (count_we && !cur_ff.which) begin
         hum_mem[waddr] <= cur_ff.count;
      end
      if (rd_en) begin
         hum_tot_ff <= hum_mem[addr_tot];
         hum_cnt_ff <= hum_mem[addr_cnt];
      end
   end

   always_ff @(posedge clock) begin
      if (count_we && cur_ff.which) begin
         ai_mem[waddr] <= cur_ff.count;
      end
      if (rd_en) begin
         ai_tot_ff <= ai_mem[addr_tot];
         ai_cnt_ff <= ai_mem[addr_cnt];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_CLEAR) begin
         hpres_mem[clr_ff] <= 1'b0;
      end else if (count_we && !cur_ff.which) begin
         hpres_mem[wrow] <= 1'b1;
      end
      if (rd_en) begin
         hpres_ff <= hpres_mem[rrow];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_CLEAR) begin
         apres_mem[clr_ff] <= 1'b0;
      end else if (count_we && cur_ff.which) begin
         apres_mem[wrow] <= 1'b1;
      end
      if (rd_en) begin
         apres_ff <= apres_mem[rrow];
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_human_cost  = rh_ff;
   assign rsp_ai_cost     = ra_ff;
   assign rsp_verdict     = rverd_ff;
   assign rsp_skipped     = rskip_ff;
   assign rsp_human_tally = rht_ff;
   assign rsp_ai_tally    = rat_ff;
endmodule
`default_nettype wire

/* bench/context_model_text_scorer_checker.sv */
// context_model_text_scorer_checker: watches the req_, csr_ and rsp_ channels of the
// scorer, predicts every result beat and compares it field by field
// depends on cmts_pkg
`default_nettype none
module context_model_text_scorer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic        req_has_byte,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_map_enable,
   input  wire logic [6:0]  req_symbol_index,
   input  wire logic        req_which_model,
   input  wire logic [11:0] req_context_code,
   input  wire logic [31:0] req_count_value,
   input  wire logic        req_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [39:0] rsp_human_cost,
   input  wire logic [39:0] rsp_ai_cost,
   input  wire logic        rsp_verdict,
   input  wire logic        rsp_skipped,
   input  wire logic [31:0] rsp_human_tally,
   input  wire logic [31:0] rsp_ai_tally,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               error_count,
   output int               pending_count,
   output int               verdict_count,
   output int               skip_count
);
   import cmts_pkg::*;

   localparam int NSYM = 64;
   localparam int COLS = 65;
   localparam logic [39:0] COST_MAX = '1;

   typedef struct packed {
      logic [39:0] human_cost;
      logic [39:0] ai_cost;
      logic        verdict;
      logic        skipped;
      logic [31:0] human_tally;
      logic [31:0] ai_tally;
   } score_type;

   score_type   score_queue[$];
   logic        map_in[256];
   logic [5:0]  map_symbol[256];
   logic [31:0] human_counts[int];
   logic [31:0] ai_counts[int];
   logic        row_loaded[2][4096];
   logic [11:0] history;
   int unsigned seen;
   logic [39:0] human_sum, ai_sum;
   logic [31:0] human_total, ai_total;
   logic [1:0]  order_reg;
   logic [6:0]  size_reg;
   logic [15:0] alpha_reg;

   function automatic logic [63:0] log2_fixed(input logic [63:0] x);
      int          e;
      logic [63:0] m, frac;
      logic [127:0] sq;
      if (x == 0) return 0;
      e = 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      m = (e >= 31) ? x >> (e - 31) : x << (31 - e);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         sq = m * m;
         m = sq[94:31];
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << 16) | frac;
   endfunction

   function automatic logic [39:0] add_sat(input logic [39:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return (s > 65'(COST_MAX)) ? COST_MAX : s[39:0];
   endfunction

   function automatic logic [63:0] model_bits(input bit ai, input int row, input int s,
                                               input int n, input int a);
      logic [63:0] d, q, ld, lq, tot, cnt;
      if (!row_loaded[ai][row]) return log2_fixed(64'(n));
      tot = ai ? ai_counts[row * COLS + n] : human_counts[row * COLS + n];
      cnt = ai ? ai_counts[row * COLS + s] : human_counts[row * COLS + s];
      d = (tot << 8) + 64'(a) * 64'(n);
      q = (cnt << 8) + 64'(a);
      ld = log2_fixed(d);
      lq = log2_fixed(q);
      return (ld >= lq) ? ld - lq : 0;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic score_beat();
      int k, n, a, s, row;
      logic [11:0] mask;
      score_type r;
      bit skip, ai;
      k = (order_reg == 0) ? 1 : (order_reg > 2) ? 2 : order_reg;
      n = (size_reg == 0) ? 1 : (size_reg > NSYM) ? NSYM : size_reg;
      a = (alpha_reg == 0) ? 1 : alpha_reg;
      mask = (k == 1) ? 12'h03f : 12'hfff;
      if (req_has_byte && map_in[req_byte_value] && map_symbol[req_byte_value] < n) begin
         s = map_symbol[req_byte_value];
         if (seen >= k) begin
            row = history & mask;
            human_sum = add_sat(human_sum, model_bits(0, row, s, n, a));
            ai_sum = add_sat(ai_sum, model_bits(1, row, s, n, a));
         end else begin
            seen++;
         end
         history = ((history << 6) | 12'(s)) & mask;
      end
      if (!req_last) return;
      skip = seen < k;
      ai = !skip && human_sum > ai_sum;
      if (!skip) begin
         if (ai) begin
            if (ai_total != '1) ai_total++;
         end else if (human_total != '1) begin
            human_total++;
         end
      end
      r.human_cost = skip ? 0 : human_sum;
      r.ai_cost = skip ? 0 : ai_sum;
      r.verdict = ai;
      r.skipped = skip;
      r.human_tally = human_total;
      r.ai_tally = ai_total;
      score_queue.push_back(r);
      history = 0;
      seen = 0;
      human_sum = 0;
      ai_sum = 0;
   endtask

   initial begin
      error_count = 0;
      verdict_count = 0;
      skip_count = 0;
   end

   assign pending_count = score_queue.size();

   always @(posedge clock) begin
      score_type w;
      if (reset) begin
         score_queue.delete();
         human_counts.delete();
         ai_counts.delete();
         foreach (map_in[i]) begin
            map_in[i] = 0;
            map_symbol[i] = 0;
         end
         foreach (row_loaded[m, r]) row_loaded[m][r] = 0;
         history = 0;
         seen = 0;
         human_sum = 0;
         ai_sum = 0;
         human_total = 0;
         ai_total = 0;
         order_reg = 2;
         size_reg = 64;
         alpha_reg = 256;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (score_queue.size() == 0) begin
               $display("result beat with nothing expected");
               error_count++;
            end else begin
               w = score_queue.pop_front();
               if (rsp_human_cost !== w.human_cost)
                  report("human_cost", rsp_human_cost, w.human_cost);
               if (rsp_ai_cost !== w.ai_cost) report("ai_cost", rsp_ai_cost, w.ai_cost);
               if (rsp_verdict !== w.verdict) report("verdict", rsp_verdict, w.verdict);
               if (rsp_skipped !== w.skipped) report("skipped", rsp_skipped, w.skipped);
               if (rsp_human_tally !== w.human_tally)
                  report("human_tally", rsp_human_tally, w.human_tally);
               if (rsp_ai_tally !== w.ai_tally) report("ai_tally", rsp_ai_tally, w.ai_tally);
               if (w.skipped) skip_count++;
               else verdict_count++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORDER: order_reg = csr_data[1:0];
               CSR_ASIZE: size_reg = csr_data[6:0];
               CSR_ALPHA: alpha_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_SCORE: score_beat();
               CMD_MAP: begin
                  map_in[req_byte_value] = req_map_enable && req_symbol_index < NSYM;
                  map_symbol[req_byte_value] = map_in[req_byte_value] ? req_symbol_index[5:0] : 0;
               end
               CMD_COUNT: begin
                  if (req_symbol_index <= NSYM) begin
                     if (req_which_model)
                        ai_counts[req_context_code * COLS + req_symbol_index] = req_count_value;
                     else
                        human_counts[req_context_code * COLS + req_symbol_index] = req_count_value;
                     row_loaded[req_which_model][req_context_code] = 1;
                  end
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

/* bench/context_model_text_scorer_tb.sv */
// context_model_text_scorer_tb: clock, reset, stimulus and verdict for the scorer
// depends on cmts_pkg, context_model_text_scorer and context_model_text_scorer_checker
`default_nettype none
module context_model_text_scorer_tb;
   import cmts_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_SCORE;
   logic        req_has_byte = 0;
   logic [7:0]  req_byte_value = 0;
   logic        req_map_enable = 0;
   logic [6:0]  req_symbol_index = 0;
   logic        req_which_model = 0;
   logic [11:0] req_context_code = 0;
   logic [31:0] req_count_value = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [39:0] rsp_human_cost, rsp_ai_cost;
   logic        rsp_verdict, rsp_skipped;
   logic [31:0] rsp_human_tally, rsp_ai_tally;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ORDER;
   logic [15:0] csr_data = 0;

   int error_count, pending_count, verdict_count, skip_count;
   int cycle_count = 0;
   bit hold_receiver = 0;
   bit random_stall = 0;
   int item_count = 0;

   always #4 clock = ~clock;

   context_model_text_scorer dut (.*);

   context_model_text_scorer_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, long hold while hold_receiver is set
   always @(posedge clock) begin
      if (hold_receiver) rsp_stall <= 1;
      else if (!random_stall) rsp_stall <= 0;
      else if ($urandom_range(0, 9) < 3) rsp_stall <= 1;
      else if ($urandom_range(0, 29) == 0) rsp_stall <= 1;
      else rsp_stall <= 0;
   end

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (g) @(posedge clock);
   endtask

   task automatic send(input logic [1:0] cmd, input logic hb, input logic [7:0] bv,
                       input logic me, input logic [6:0] si, input logic wm,
                       input logic [11:0] cc, input logic [31:0] cv, input logic last);
      req_valid <= 1;
      req_cmd <= cmd;
      req_has_byte <= hb;
      req_byte_value <= bv;
      req_map_enable <= me;
      req_symbol_index <= si;
      req_which_model <= wm;
      req_context_code <= cc;
      req_count_value <= cv;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 0;
      item_count++;
      idle_gap();
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // symbol columns 0..4 and total column 64 cover every alphabet size used
   task automatic load_row_both(input logic [11:0] row, input bit random_counts);
      logic [31:0] c;
      int col;
      for (int m = 0; m < 2; m++)
         for (int j = 0; j < 6; j++) begin
            col = (j == 5) ? 64 : j;
            c = random_counts ? (($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 900))
                              : 32'(col);
            send(CMD_COUNT, $urandom, $urandom, $urandom, 7'(col), m[0], row, c, $urandom);
         end
   endtask

   // a sample of symbols over a small set so that loaded rows are reused
   task automatic score_sample(input int len);
      int s;
      bit in_alpha;
      for (int i = 0; i < len; i++) begin
         in_alpha = $urandom_range(0, 9) != 0;
         s = $urandom_range(0, 3);
         send(CMD_SCORE, $urandom_range(0, 15) != 0, in_alpha ? 8'(s + 8'h41) : 8'(8'hc0 + s),
              $urandom, $urandom, $urandom, $urandom, $urandom, i == len - 1);
      end
      if (len == 0)
         send(CMD_SCORE, 0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
   endtask

   initial begin
      int pick;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // alphabet: bytes 0x41..0x44 map to symbols 0..3, 0xc0.. absent
      for (int b = 0; b < 4; b++) send(CMD_MAP, 0, 8'(8'h41 + b), 1, 7'(b), 0, 0, 0, 1);
      send(CMD_MAP, 0, 8'hc0, 1, 7'd64, 0, 0, 0, 0);
      send(CMD_MAP, 0, 8'hff, 1, 7'd63, 0, 0, 0, 0);
      send(CMD_MAP, 0, 8'hff, 0, 7'd3, 0, 0, 0, 0);
      send(CMD_MAP, 0, 8'h00, 1, 7'd40, 0, 0, 0, 0);
      // column above range is dropped
      send(CMD_COUNT, 0, 0, 0, 7'd127, 1, 12'hfff, 32'hffffffff, 0);
      send(3, 1, 8'h41, 1, 7'd1, 1, 12'h001, 32'h5, 1);
      // rows 0..3 (order 1 contexts of symbols 0..3, order 2 contexts after symbol 0) and order 2 row 0x041
      for (int r = 0; r < 4; r++) load_row_both(12'(r), r == 3 ? 0 : 1);
      load_row_both(12'h041, 1);
      send(CMD_COUNT, 0, 0, 0, 7'd64, 0, 12'h041, 32'hffffffff, 0);
      send(CMD_COUNT, 0, 0, 0, 7'd2, 1, 12'h041, 32'hffffffff, 0);

      score_sample(0);
      score_sample(1);
      score_sample(6);
      send(CMD_SCORE, 1, 8'h00, 0, 0, 0, 0, 0, 0);
      send(CMD_SCORE, 1, 8'h41, 0, 0, 0, 0, 0, 0);
      send(CMD_SCORE, 1, 8'h42, 0, 0, 0, 0, 0, 0);
      send(CMD_SCORE, 1, 8'h43, 0, 0, 0, 0, 0, 1);
      drain();

      random_stall = 1;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin csr_write(CSR_ORDER, 1); csr_write(CSR_ALPHA, 1); end
            1: begin csr_write(CSR_ASIZE, 4); csr_write(CSR_ALPHA, 16'hffff); end
            2: begin csr_write(CSR_ORDER, 0); csr_write(CSR_ASIZE, 0); end
            3: begin csr_write(CSR_ORDER, 3); csr_write(CSR_ASIZE, 127);
                     csr_write(CSR_ALPHA, 0); end
            4: begin csr_write(CSR_ORDER, 2); csr_write(CSR_ASIZE, 64);
                     csr_write(CSR_ALPHA, 16'h0180); end
            default: begin csr_write(CSR_ORDER, 1); csr_write(CSR_ASIZE, 3); end
         endcase
         for (int j = 0; j < 24; j++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               send(CMD_MAP, 0, 8'(8'h41 + $urandom_range(0, 3)), 1, 7'($urandom_range(0, 3)),
                    0, 0, 0, 0);
            else if (pick == 1)
               send(CMD_COUNT, 0, 0, 0, 7'($urandom_range(0, 64)), $urandom,
                    12'($urandom_range(0, 3)), $urandom, 0);
            else
               score_sample($urandom_range(0, 7));
            if (phase == 2 && j == 4) begin
               // long hold: block fills and stalls its input
               fork
                  begin
                     hold_receiver = 1;
                     repeat (600) @(posedge clock);
                     hold_receiver = 0;
                  end
                  for (int t = 0; t < 4; t++) score_sample(2);
               join
            end
            if (j == 7) while (pending_count != 0) @(posedge clock);
         end
         drain();
      end
      random_stall = 0;
      drain();

      $display("%0d items sent, %0d samples scored, %0d skipped, six register settings",
               item_count, verdict_count, skip_count);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
